// ----- sv/rwsp_pkg.sv -----
// rwsp_pkg: shared types, constants and the cosine table function for the wall slice projector
// no dependencies; imported by every module of the block
package rwsp_pkg;

  localparam int unsigned MaxRaysDefault  = 4096;
  localparam int unsigned CosDepthDefault = 1024;
  localparam logic [63:0] PiQ30           = 64'd3373259426;
  localparam logic [14:0] OneQ14          = 15'd16384;
  localparam int unsigned DivSteps        = 15;

  typedef enum logic [2:0] {
    CfgProjDistance = 3'd0,
    CfgViewHeight   = 3'd1,
    CfgNumRays      = 3'd2,
    CfgStartAngle   = 3'd3,
    CfgAngleStep    = 3'd4,
    CfgPlayerAngle  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] ray_index;
    logic        ray_hit;
    logic [23:0] hit_distance;
  } in_req_t;

  typedef struct packed {
    logic [11:0]        slice_index;
    logic signed [15:0] left_x;
    logic signed [15:0] right_x;
    logic signed [15:0] top_y;
    logic signed [15:0] bottom_y;
  } out_req_t;

  // one stage of the shared divider pipe
  typedef struct packed {
    logic        valid;
    logic [11:0] idx;
    logic [12:0] n;
    logic [51:0] den;
    logic [55:0] rem_h;
    logic [27:0] rem_l;
    logic [27:0] rem_r;
    logic [13:0] qh;
    logic [14:0] ql;
    logic [14:0] qr;
    logic        hsat;
    logic        lsat;
    logic        rsat;
  } div_stage_t;

  // taylor term divided by a*(a+1), a = 2n or 2n-1
  function automatic logic [63:0] term_div(input logic [63:0] t, input logic odd,
                                           input int unsigned n);
    logic [63:0] r;
    r = t;
    case ({odd, 3'(n)})
      4'b0001: r = t / 64'd2;
      4'b0010: r = t / 64'd12;
      4'b0011: r = t / 64'd30;
      4'b0100: r = t / 64'd56;
      4'b0101: r = t / 64'd90;
      4'b0110: r = t / 64'd132;
      4'b0111: r = t / 64'd182;
      4'b1001: r = t / 64'd6;
      4'b1010: r = t / 64'd20;
      4'b1011: r = t / 64'd42;
      4'b1100: r = t / 64'd72;
      4'b1101: r = t / 64'd110;
      4'b1110: r = t / 64'd156;
      4'b1111: r = t / 64'd210;
      default: r = t;
    endcase
    return r;
  endfunction

  // sine or cosine over one quadrant, result q14
  function automatic logic [14:0] quarter_series(input logic [13:0] r, input logic odd);
    logic [63:0]     x;
    logic [63:0]     x2;
    logic [63:0]     term;
    logic [63:0]     q;
    longint signed   sum;
    x    = (64'(r) * PiQ30) >> 15;
    x2   = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    sum  = longint'(term);
    for (int unsigned n = 1; n <= 7; n++) begin
      term = term_div((term * x2) >> 30, odd, n);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (64'(sum) + 64'd32768) >> 16;
    if (q > 64'(OneQ14)) q = 64'(OneQ14);
    return q[14:0];
  endfunction

  function automatic logic signed [15:0] cos_turns(input logic [15:0] a);
    logic [15:0] v;
    case (a[15:14])
      2'd0:    v = {1'b0, quarter_series(a[13:0], 1'b0)};
      2'd1:    v = -{1'b0, quarter_series(a[13:0], 1'b1)};
      2'd2:    v = -{1'b0, quarter_series(a[13:0], 1'b0)};
      default: v = {1'b0, quarter_series(a[13:0], 1'b1)};
    endcase
    return v;
  endfunction

endpackage

// ----- sv/rwsp_cos_rom.sv -----
// rwsp_cos_rom: constant cosine table with registered read
// depends on rwsp_pkg for the table function
module rwsp_cos_rom #(
  parameter int unsigned CosDepth = rwsp_pkg::CosDepthDefault,
  localparam int unsigned Aw      = $clog2(CosDepth)
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [Aw-1:0]        addr_i,
  output logic signed [15:0]   data_o
);
  import rwsp_pkg::*;

  logic signed [15:0] rom_w [CosDepth];
  logic signed [15:0] data_q;

  for (genvar k = 0; k < CosDepth; k++) begin : g_rom
    localparam logic [15:0] Ang = 16'((64'(k) * 64'd65536) / CosDepth);
    assign rom_w[k] = cos_turns(Ang);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// ----- sv/rwsp_div_pipe.sv -----
// rwsp_div_pipe: restoring divider pipe, one quotient bit per stage
// depends on rwsp_pkg for the stage struct
module rwsp_div_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  rwsp_pkg::div_stage_t  in_i,
  output rwsp_pkg::div_stage_t  out_o
);
  import rwsp_pkg::*;

  div_stage_t st_d [DivSteps];
  div_stage_t st_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    localparam int unsigned B = DivSteps - 1 - k;
    // height quotient bit of this stage, none in the first stage
    localparam logic [13:0] QhBit = 14'(15'd1 << B);
    div_stage_t src;
    logic [27:0] nsh;
    logic [65:0] dsh;
    logic [65:0] rh;
    logic        hge;

    if (k == 0) begin : g_first
      assign src = in_i;
    end else begin : g_next
      assign src = st_q[k-1];
    end

    assign nsh = 28'(src.n) << B;
    assign dsh = 66'(src.den) << B;
    assign rh  = 66'(src.rem_h);
    assign hge = rh >= dsh;

    always_comb begin
      st_d[k] = src;
      // x quotient bits for both edges
      if (src.rem_l >= nsh) begin
        st_d[k].rem_l = src.rem_l - nsh;
        st_d[k].ql[B] = 1'b1;
      end
      if (src.rem_r >= nsh) begin
        st_d[k].rem_r = src.rem_r - nsh;
        st_d[k].qr[B] = 1'b1;
      end
      if (hge) begin
        if (k == 0) begin
          // quotient of one or more saturates the height
          st_d[k].hsat = 1'b1;
        end else begin
          st_d[k].rem_h = 56'(rh - dsh);
          st_d[k].qh    = src.qh | QhBit;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k].valid <= 1'b0;
      end else if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_o = st_q[DivSteps-1];

endmodule

// ----- sv/raycast_wall_slice_projector.sv -----
// raycast_wall_slice_projector: fisheye corrected wall slice projection, top level
// depends on rwsp_pkg, rwsp_cos_rom and rwsp_div_pipe
// pipeline: 4 front stages, 15 divider stages, output register
// throughput: one request per cycle unless a held result stalls the pipe;
//   missed rays leave as bubbles and give no result
// reset: asynchronous active low, clears valid bits and loads register defaults
module raycast_wall_slice_projector #(
  parameter int unsigned MaxRays  = rwsp_pkg::MaxRaysDefault,
  parameter int unsigned CosDepth = rwsp_pkg::CosDepthDefault,
  localparam int unsigned Aw      = $clog2(CosDepth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  rwsp_pkg::in_req_t  in_req_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output rwsp_pkg::out_req_t out_req_o,
  input  logic               out_stall_i
);
  import rwsp_pkg::*;

  // configuration registers
  logic [23:0] proj_distance_q;
  logic [12:0] view_height_q;
  logic [12:0] num_rays_q;
  logic [15:0] start_angle_q;
  logic [15:0] angle_step_q;
  logic [15:0] player_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_distance_q <= 24'd141890;
      view_height_q   <= 13'd480;
      num_rays_q      <= 13'd640;
      start_angle_q   <= 16'd60075;
      angle_step_q    <= 16'd17;
      player_angle_q  <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgProjDistance: proj_distance_q <= cfg_data_i;
        CfgViewHeight:   view_height_q   <= cfg_data_i[12:0];
        CfgNumRays:      num_rays_q      <= cfg_data_i[12:0];
        CfgStartAngle:   start_angle_q   <= cfg_data_i[15:0];
        CfgAngleStep:    angle_step_q    <= cfg_data_i[15:0];
        CfgPlayerAngle:  player_angle_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // one enable for the whole pipe: it moves unless the output holds a stalled result
  logic out_valid_q;
  logic en;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: ray angle product, column count clamp, edge saturation flags
  logic [12:0] n_eff;
  always_comb begin
    if (num_rays_q == 13'd0)              n_eff = 13'd1;
    else if (32'(num_rays_q) > MaxRays)   n_eff = 13'(MaxRays);
    else                                  n_eff = num_rays_q;
  end

  logic        v1_q;
  logic [11:0] idx1_q;
  logic [23:0] dist1_q;
  logic [15:0] ang1_q;
  logic [12:0] n1_q;
  logic        lsat1_q;
  logic        rsat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i && in_req_i.ray_hit;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q  <= in_req_i.ray_index;
      dist1_q <= in_req_i.hit_distance;
      ang1_q  <= 16'(in_req_i.ray_index * angle_step_q);
      n1_q    <= n_eff;
      // left edge pins at plus one once the index reaches the column count
      lsat1_q <= 13'(in_req_i.ray_index) >= n_eff;
      rsat1_q <= (13'(in_req_i.ray_index) + 13'd1) >= n_eff;
    end
  end

  // stage 2: angle relative to heading, cosine table lookup
  logic [15:0]        diff;
  logic [32:0]        tix_prod;
  logic signed [15:0] cos2;
  assign diff     = start_angle_q + ang1_q - player_angle_q;
  assign tix_prod = 33'(diff) * 33'(CosDepth);

  rwsp_cos_rom #(.CosDepth(CosDepth)) u_cos_rom (
    .clk_i  (clk_i),
    .en_i   (en),
    .addr_i (tix_prod[16 +: Aw]),
    .data_o (cos2)
  );

  logic        v2_q;
  logic [11:0] idx2_q;
  logic [23:0] dist2_q;
  logic [12:0] n2_q;
  logic        lsat2_q;
  logic        rsat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx2_q  <= idx1_q;
      dist2_q <= dist1_q;
      n2_q    <= n1_q;
      lsat2_q <= lsat1_q;
      rsat2_q <= rsat1_q;
    end
  end

  // stage 3: fisheye corrected distance, q12.26
  logic        v3_q;
  logic [11:0] idx3_q;
  logic [12:0] n3_q;
  logic        lsat3_q;
  logic        rsat3_q;
  logic        full3_q;
  logic [38:0] corr3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx3_q  <= idx2_q;
      n3_q    <= n2_q;
      lsat3_q <= lsat2_q;
      rsat3_q <= rsat2_q;
      // wall behind the viewer, zero distance or zero height: full height
      full3_q <= (cos2 <= 16'sd0) || (dist2_q == 24'd0) || (view_height_q == 13'd0);
      corr3_q <= 39'(dist2_q) * 39'(cos2[14:0]);
    end
  end

  // stage 4: scale by view height to form the divisor
  logic        v4_q;
  logic [11:0] idx4_q;
  logic [12:0] n4_q;
  logic        lsat4_q;
  logic        rsat4_q;
  logic        full4_q;
  logic [51:0] den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx4_q  <= idx3_q;
      n4_q    <= n3_q;
      lsat4_q <= lsat3_q;
      rsat4_q <= rsat3_q;
      full4_q <= full3_q;
      den4_q  <= 52'(corr3_q) * 52'(view_height_q);
    end
  end

  // divider pipe: height quotient and both column edges in lockstep
  div_stage_t div_in;
  div_stage_t div_out;
  always_comb begin
    div_in       = '0;
    div_in.valid = v4_q;
    div_in.idx   = idx4_q;
    div_in.n     = n4_q;
    div_in.den   = den4_q;
    div_in.rem_h = {proj_distance_q, 32'd0};
    div_in.rem_l = 28'(idx4_q) << 15;
    div_in.rem_r = (28'(idx4_q) + 28'd1) << 15;
    div_in.hsat  = full4_q;
    div_in.lsat  = lsat4_q;
    div_in.rsat  = rsat4_q;
  end

  rwsp_div_pipe u_div_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (div_in),
    .out_o  (div_out)
  );

  // output register: q2.14 edges and heights
  logic [14:0] h;
  logic [15:0] lq;
  logic [15:0] rq;
  assign h  = div_out.hsat ? OneQ14 : {1'b0, div_out.qh};
  assign lq = div_out.lsat ? 16'd32768 : {1'b0, div_out.ql};
  assign rq = div_out.rsat ? 16'd32768 : {1'b0, div_out.qr};

  out_req_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= div_out.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.slice_index <= div_out.idx;
      out_q.left_x      <= lq - 16'd16384;
      out_q.right_x     <= rq - 16'd16384;
      out_q.top_y       <= {1'b0, h};
      out_q.bottom_y    <= -{1'b0, h};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTH
  a_stall_only_on_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.top_y >= 16'sd0 && out_q.top_y <= 16'sd16384))
    else $error("half height out of range");

  a_height_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.bottom_y == -out_q.top_y))
    else $error("bottom is not the mirror of top");

  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.left_x <= out_q.right_x))
    else $error("left edge right of right edge");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for raycast_wall_slice_projector
// depends on rwsp_pkg and the block; a scoreboard class predicts each slice from its own cos table

module testbench;
  import rwsp_pkg::*;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned DrainCycles = 30;
  localparam logic [2:0] CfgSpare = 3'd7;

  // scoreboard: own copy of the registers, own cos table, queue of predicted slices
  class slice_scoreboard;
    int signed    cos_tab[1024];
    logic [23:0]  proj;
    logic [12:0]  vh;
    logic [12:0]  nrays;
    logic [15:0]  start;
    logic [15:0]  step;
    logic [15:0]  player;
    out_req_t     pending[$];
    int           errors;

    function new();
      int unsigned a;
      int signed v;
      for (int k = 0; k < 1024; k++) begin
        a = k * 64;
        case (a >> 14)
          0: v = quarter(a & 16383, 0);
          1: v = -quarter(a & 16383, 1);
          2: v = -quarter(a & 16383, 0);
          default: v = quarter(a & 16383, 1);
        endcase
        cos_tab[k] = v;
      end
      errors = 0;
      reset_regs();
    endfunction

    // truncating taylor series in q30, rounded to q14
    function int signed quarter(int unsigned r, bit odd);
      longint unsigned x, x2, term, a, q;
      longint signed sum;
      x = (longint'(r) * 64'd3373259426) >> 15;
      x2 = (x * x) >> 30;
      term = odd ? x : (64'd1 << 30);
      sum = longint'(term);
      for (int n = 1; n <= 7; n++) begin
        a = odd ? 2 * n : 2 * n - 1;
        term = ((term * x2) >> 30) / (a * (a + 1));
        if (n % 2) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      q = (longint'(sum) + 32768) >> 16;
      if (q > 16384) q = 16384;
      return int'(q);
    endfunction

    function void reset_regs();
      proj = 24'd141890;
      vh = 13'd480;
      nrays = 13'd640;
      start = 16'd60075;
      step = 16'd17;
      player = 16'd0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        CfgProjDistance: proj = d;
        CfgViewHeight: vh = d[12:0];
        CfgNumRays: nrays = d[12:0];
        CfgStartAngle: start = d[15:0];
        CfgAngleStep: step = d[15:0];
        CfgPlayerAngle: player = d[15:0];
        default: ;
      endcase
    endfunction

    function void note_request(in_req_t r);
      logic [15:0] ang, diff;
      int signed c;
      longint unsigned h, den, n, lq, rq;
      out_req_t e;
      if (!r.ray_hit) return;
      ang = start + r.ray_index * step;
      diff = ang - player;
      c = cos_tab[diff >> 6];
      if (c <= 0 || r.hit_distance == 0 || vh == 0) begin
        h = 16384;
      end else begin
        den = longint'(r.hit_distance) * longint'(c) * longint'(vh);
        h = (longint'(proj) << 32) / den;
        if (h > 16384) h = 16384;
      end
      n = nrays;
      if (n == 0) n = 1;
      if (n > 4096) n = 4096;
      lq = (longint'(r.ray_index) * 32768) / n;
      rq = ((longint'(r.ray_index) + 1) * 32768) / n;
      if (lq > 32768) lq = 32768;
      if (rq > 32768) rq = 32768;
      e.slice_index = r.ray_index;
      e.left_x = 16'(lq - 16384);
      e.right_x = 16'(rq - 16384);
      e.top_y = 16'(h);
      e.bottom_y = 16'(0 - h);
      pending = {pending, e};
    endfunction

    function void check_slice(out_req_t a);
      out_req_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected slice idx %0d", a.slice_index);
        return;
      end
      e = pending.pop_front();
      if (e != a) begin
        errors++;
        if (errors <= 10)
          $display("slice mismatch exp idx %0d l %0d r %0d t %0d b %0d / got %0d %0d %0d %0d %0d",
                   e.slice_index, e.left_x, e.right_x, e.top_y, e.bottom_y,
                   a.slice_index, a.left_x, a.right_x, a.top_y, a.bottom_y);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  in_req_t     in_req_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_req_t    out_req_o;
  logic        out_stall_i = 1'b0;

  slice_scoreboard sb = new();
  bit quiet = 0;      // phase with no gaps and no stalls
  int stall_left = 0;
  int idle_cycles = 0;

  raycast_wall_slice_projector dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_req_i, .in_stall_o,
    .out_valid_o, .out_req_o, .out_stall_i
  );

  always #5 clk_i = ~clk_i;

  // mostly no gap, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check accepted slices, then decide the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_slice(out_req_o);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic send_request(logic [11:0] idx, logic hit, logic [23:0] hit_dist);
    in_req_t r;
    int gap;
    r.ray_index = idx;
    r.ray_hit = hit;
    r.hit_distance = hit_dist;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  // wait for every predicted slice, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_val(int p, logic [23:0] lo, logic [23:0] hi,
                                           logic [23:0] rnd);
    int r;
    if (p == 0) return lo;
    if (p == 1) return hi;
    r = $urandom_range(0, 5);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return rnd;
  endfunction

  initial begin
    int n;
    logic [11:0] idx;
    logic [23:0] hit_dist;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, misses, distance extremes, index extremes
    send_request(12'd0, 1'b1, 24'd4096);
    send_request(12'd5, 1'b0, 24'd4096);
    send_request(12'd639, 1'b1, 24'd1);
    send_request(12'd640, 1'b1, 24'hFFFFFF);
    send_request(12'd4095, 1'b1, 24'd0);
    send_request(12'd320, 1'b1, 24'd100);
    send_request(12'd100, 1'b1, 24'd20000);
    send_request(12'hAAA, 1'b0, 24'h555555);
    drain();
    // quarter turn steps: zero view height and spare index, then cos one, zero, negative
    write_reg(CfgStartAngle, 24'd0);
    write_reg(CfgAngleStep, 24'd16384);
    write_reg(CfgViewHeight, 24'd0);
    write_reg(CfgSpare, 24'hFFFFFF);
    send_request(12'd0, 1'b1, 24'd4096);
    drain();
    write_reg(CfgViewHeight, 24'd480);
    for (int k = 0; k < 5; k++) send_request(12'(k), 1'b1, 24'd300);
    drain();

    for (int p = 0; p < 8; p++) begin
      quiet = (p == 3);
      write_reg(CfgProjDistance,
                pick_val(p, 24'd0, 24'hFFFFFF, 24'($urandom_range(1000, 2000000))));
      write_reg(CfgViewHeight, pick_val(p, 24'd0, 24'd8191, 24'($urandom_range(1, 4096))));
      write_reg(CfgNumRays, pick_val(p, 24'd0, 24'd8191, 24'($urandom_range(1, 4096))));
      write_reg(CfgStartAngle, pick_val(p, 24'd0, 24'hFFFF, 24'($urandom_range(0, 65535))));
      write_reg(CfgAngleStep, pick_val(p, 24'd0, 24'hFFFF, 24'($urandom_range(0, 64))));
      write_reg(CfgPlayerAngle, pick_val(p, 24'd0, 24'hFFFF, 24'($urandom_range(0, 65535))));
      write_reg(CfgSpare - 3'd1, 24'($urandom));
      n = (sb.nrays == 0) ? 1 : (sb.nrays > 4096 ? 4096 : sb.nrays);
      for (int k = 0; k < 190; k++) begin
        if ($urandom_range(0, 9) < 8) idx = 12'($urandom_range(0, n - 1));
        else idx = 12'($urandom);
        case ($urandom_range(0, 2))
          0: hit_dist = 24'($urandom);
          1: hit_dist = 24'($urandom_range(0, 8192));
          default: hit_dist = 24'($urandom & ((32'd1 << $urandom_range(0, 24)) - 1));
        endcase
        send_request(idx, $urandom_range(0, 9) < 8, hit_dist);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
